>>> rtl/core/ptt_pkg.sv
// Package for the periodic task timer table.
// Holds sizing constants, operation codes and the controller/datapath interface types.
// No dependencies.
package ptt_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 8;
  localparam int unsigned ID_W           = 8;
  localparam int unsigned PERIOD_W       = 32;
  localparam int unsigned STEP_W         = 16;
  localparam logic [STEP_W-1:0] TICK_STEP_RST = 16'd10;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_DEL   = 2'd2,
    OP_CHECK = 2'd3
  } ptt_op_t;

  typedef enum logic [1:0] {
    WR_TICK    = 2'd0,
    WR_ADD_HIT = 2'd1,
    WR_ADD_NEW = 2'd2,
    WR_MOVE    = 2'd3
  } ptt_wr_t;

  typedef enum logic [1:0] {
    EM_NONE     = 2'd0,
    EM_FIRE     = 2'd1,
    EM_TICK_END = 2'd2,
    EM_REPLY    = 2'd3
  } ptt_emit_t;

  typedef struct packed {
    logic      load;
    logic      rd_last;
    logic      idx_inc;
    logic      wr_en;
    ptt_wr_t   wr_sel;
    logic      save_slot;
    logic      used_inc;
    logic      used_dec;
    logic      pend_set;
    ptt_emit_t emit;
    logic      ok;
    logic      rem_hit;
  } ptt_cmd_t;

  typedef struct packed {
    ptt_op_t op;
    logic    scan_end;
    logic    full;
    logic    match;
    logic    fire;
    logic    pend_valid;
  } ptt_sts_t;

endpackage

>>> rtl/core/periodic_task_timer_table.sv
// Periodic task timer table, top level.
// Joins the controller ptt_ctrl and the datapath ptt_dp; uses ptt_pkg.
//
// An operation is accepted when start is high and busy is low; busy then stays high
// while the slot table is scanned, and results appear on out_* for one cycle each,
// marked by out_strobe, with no way to hold them off. The slot table is a
// memory with a registered read port and a separate write port, so each scanned slot
// passes through a read state and an evaluate state. The scan runs past the last used
// slot on every tick and on an add, delete or check of an absent task, and stops on
// the matching slot otherwise; a delete that finds its task then moves the last slot
// into the freed slot, and an add to a full table replies without scanning. A tick
// returns one transaction per fired task in slot order, or a single transaction with
// out_fired low; out_last marks the final one. cfg_wdata sets the tick step; the user
// must write it only while busy is low, which the block itself does not enforce.
module periodic_task_timer_table #(
  parameter int unsigned SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_operation,
  input  logic [ptt_pkg::ID_W-1:0]      in_task_id,
  input  logic [ptt_pkg::PERIOD_W-1:0]  in_period,
  input  logic                          cfg_we,
  input  logic [ptt_pkg::STEP_W-1:0]    cfg_wdata,
  output logic                          out_strobe,
  output logic [1:0]                    out_kind,
  output logic                          out_fired,
  output logic [ptt_pkg::ID_W-1:0]      out_fired_task,
  output logic                          out_ok,
  output logic [ptt_pkg::PERIOD_W-1:0]  out_remaining,
  output logic                          out_last
);

  ptt_pkg::ptt_cmd_t cmd;
  ptt_pkg::ptt_sts_t sts;

  ptt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ptt_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_operation),
    .in_task_id     (in_task_id),
    .in_period      (in_period),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_fired      (out_fired),
    .out_fired_task (out_fired_task),
    .out_ok         (out_ok),
    .out_remaining  (out_remaining),
    .out_last       (out_last)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> (busy || out_strobe))
    else $error("tick ended without a final transaction");

  a_reply_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind != ptt_pkg::OP_TICK) |-> (out_last && !out_fired))
    else $error("reply not marked as single final transaction");

  a_result_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without an operation in progress");
`endif

endmodule

>>> rtl/core/ptt_ctrl.sv
// Controller for the periodic task timer table.
// Sequences the slot scan and issues commands to ptt_dp; uses ptt_pkg types.
module ptt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ptt_pkg::ptt_sts_t sts,
  output ptt_pkg::ptt_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RD    = 5'b00010,
    ST_EV    = 5'b00100,
    ST_MV_RD = 5'b01000,
    ST_MV_WR = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (sts.op == ptt_pkg::OP_ADD && sts.full) begin
          cmd.emit  = ptt_pkg::EM_REPLY;
          state_nxt = ST_IDLE;
        end else if (sts.scan_end) begin
          state_nxt = ST_IDLE;
          unique case (sts.op)
            ptt_pkg::OP_TICK: begin
              cmd.emit = ptt_pkg::EM_TICK_END;
            end
            ptt_pkg::OP_ADD: begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = ptt_pkg::WR_ADD_NEW;
              cmd.used_inc = 1'b1;
              cmd.emit     = ptt_pkg::EM_REPLY;
              cmd.ok       = 1'b1;
            end
            default: begin
              cmd.emit = ptt_pkg::EM_REPLY;
            end
          endcase
        end else begin
          state_nxt = ST_EV;
        end
      end
      ST_EV: begin
        if (sts.op == ptt_pkg::OP_TICK) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = ptt_pkg::WR_TICK;
          cmd.idx_inc = 1'b1;
          if (sts.fire) begin
            cmd.pend_set = 1'b1;
            if (sts.pend_valid) begin
              cmd.emit = ptt_pkg::EM_FIRE;
            end
          end
          state_nxt = ST_RD;
        end else if (sts.match) begin
          unique case (sts.op)
            ptt_pkg::OP_ADD: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ptt_pkg::WR_ADD_HIT;
              cmd.emit   = ptt_pkg::EM_REPLY;
              cmd.ok     = 1'b1;
              state_nxt  = ST_IDLE;
            end
            ptt_pkg::OP_DEL: begin
              cmd.save_slot = 1'b1;
              state_nxt     = ST_MV_RD;
            end
            default: begin
              cmd.emit    = ptt_pkg::EM_REPLY;
              cmd.rem_hit = 1'b1;
              state_nxt   = ST_IDLE;
            end
          endcase
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_RD;
        end
      end
      ST_MV_RD: begin
        cmd.rd_last = 1'b1;
        state_nxt   = ST_MV_WR;
      end
      ST_MV_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = ptt_pkg::WR_MOVE;
        cmd.used_dec = 1'b1;
        cmd.emit     = ptt_pkg::EM_REPLY;
        cmd.ok       = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/ptt_dp.sv
// Datapath for the periodic task timer table.
// Holds the slot memory, scan index, tick step and result registers; uses ptt_pkg types.
module ptt_dp #(
  parameter int unsigned SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_operation,
  input  logic [ptt_pkg::ID_W-1:0]      in_task_id,
  input  logic [ptt_pkg::PERIOD_W-1:0]  in_period,
  input  logic                          cfg_we,
  input  logic [ptt_pkg::STEP_W-1:0]    cfg_wdata,
  input  ptt_pkg::ptt_cmd_t             cmd,
  output ptt_pkg::ptt_sts_t             sts,
  output logic                          out_strobe,
  output logic [1:0]                    out_kind,
  output logic                          out_fired,
  output logic [ptt_pkg::ID_W-1:0]      out_fired_task,
  output logic                          out_ok,
  output logic [ptt_pkg::PERIOD_W-1:0]  out_remaining,
  output logic                          out_last
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOT_COUNT);

  logic [ptt_pkg::ID_W-1:0]     task_mem   [SLOT_COUNT];
  logic [ptt_pkg::PERIOD_W-1:0] period_mem [SLOT_COUNT];
  logic [ptt_pkg::PERIOD_W-1:0] count_mem  [SLOT_COUNT];

  ptt_pkg::ptt_op_t             op_r;
  logic [ptt_pkg::ID_W-1:0]     id_r;
  logic [ptt_pkg::PERIOD_W-1:0] per_r;
  logic [ptt_pkg::STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]             idx_r;
  logic [CNT_W-1:0]             used_r;
  logic [CNT_W-1:0]             used_nxt;
  logic [IDX_W-1:0]             slot_r;
  logic                         pend_valid_r;
  logic [ptt_pkg::ID_W-1:0]     pend_task_r;

  logic [ptt_pkg::ID_W-1:0]     rd_task_r;
  logic [ptt_pkg::PERIOD_W-1:0] rd_period_r;
  logic [ptt_pkg::PERIOD_W-1:0] rd_count_r;

  logic [IDX_W-1:0]             rd_addr;
  logic [IDX_W-1:0]             wr_addr;
  logic [ptt_pkg::ID_W-1:0]     wr_task;
  logic [ptt_pkg::PERIOD_W-1:0] wr_period;
  logic [ptt_pkg::PERIOD_W-1:0] wr_count;
  logic [ptt_pkg::PERIOD_W-1:0] sum;
  logic                         fire;
  logic [CNT_W-1:0]             last_slot;

  logic                         out_strobe_r;
  logic [1:0]                   out_kind_r;
  logic                         out_fired_r;
  logic [ptt_pkg::ID_W-1:0]     out_fired_task_r;
  logic                         out_ok_r;
  logic [ptt_pkg::PERIOD_W-1:0] out_remaining_r;
  logic                         out_last_r;

  assign sum       = rd_count_r + {{(ptt_pkg::PERIOD_W-ptt_pkg::STEP_W){1'b0}}, step_r};
  assign fire      = (sum >= rd_period_r);
  assign last_slot = used_r - CNT_ONE;
  assign rd_addr   = cmd.rd_last ? last_slot[IDX_W-1:0] : idx_r[IDX_W-1:0];

  assign sts.op         = op_r;
  assign sts.scan_end   = (idx_r == used_r);
  assign sts.full       = (used_r == CNT_FULL);
  assign sts.match      = (rd_task_r == id_r);
  assign sts.fire       = fire;
  assign sts.pend_valid = pend_valid_r;

  always_comb begin
    wr_addr   = idx_r[IDX_W-1:0];
    wr_task   = rd_task_r;
    wr_period = rd_period_r;
    wr_count  = fire ? '0 : sum;
    case (cmd.wr_sel)
      ptt_pkg::WR_TICK: begin
        wr_addr = idx_r[IDX_W-1:0];
      end
      ptt_pkg::WR_ADD_HIT: begin
        wr_addr   = idx_r[IDX_W-1:0];
        wr_task   = id_r;
        wr_period = per_r;
        wr_count  = '0;
      end
      ptt_pkg::WR_ADD_NEW: begin
        wr_addr   = used_r[IDX_W-1:0];
        wr_task   = id_r;
        wr_period = per_r;
        wr_count  = '0;
      end
      default: begin
        wr_addr  = slot_r;
        wr_count = rd_count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      task_mem[wr_addr]   <= wr_task;
      period_mem[wr_addr] <= wr_period;
      count_mem[wr_addr]  <= wr_count;
    end
    rd_task_r   <= task_mem[rd_addr];
    rd_period_r <= period_mem[rd_addr];
    rd_count_r  <= count_mem[rd_addr];
  end

  always_comb begin
    used_nxt = used_r;
    if (cmd.used_inc) begin
      used_nxt = used_r + CNT_ONE;
    end else if (cmd.used_dec) begin
      used_nxt = used_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      step_r       <= ptt_pkg::TICK_STEP_RST;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      if (cmd.load) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.pend_set) begin
        pend_valid_r <= 1'b1;
      end
      out_strobe_r <= (cmd.emit != ptt_pkg::EM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= ptt_pkg::ptt_op_t'(in_operation);
      id_r  <= in_task_id;
      per_r <= in_period;
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CNT_ONE;
    end
    if (cmd.save_slot) begin
      slot_r <= idx_r[IDX_W-1:0];
    end
    if (cmd.pend_set) begin
      pend_task_r <= rd_task_r;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      ptt_pkg::EM_FIRE: begin
        out_kind_r       <= ptt_pkg::OP_TICK;
        out_fired_r      <= 1'b1;
        out_fired_task_r <= pend_task_r;
        out_ok_r         <= 1'b0;
        out_remaining_r  <= '0;
        out_last_r       <= 1'b0;
      end
      ptt_pkg::EM_TICK_END: begin
        out_kind_r       <= ptt_pkg::OP_TICK;
        out_fired_r      <= pend_valid_r;
        out_fired_task_r <= pend_valid_r ? pend_task_r : '0;
        out_ok_r         <= 1'b0;
        out_remaining_r  <= '0;
        out_last_r       <= 1'b1;
      end
      ptt_pkg::EM_REPLY: begin
        out_kind_r       <= op_r;
        out_fired_r      <= 1'b0;
        out_fired_task_r <= '0;
        out_ok_r         <= cmd.ok;
        out_remaining_r  <= cmd.rem_hit ? (rd_period_r - rd_count_r) : '0;
        out_last_r       <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_strobe     = out_strobe_r;
  assign out_kind       = out_kind_r;
  assign out_fired      = out_fired_r;
  assign out_fired_task = out_fired_task_r;
  assign out_ok         = out_ok_r;
  assign out_remaining  = out_remaining_r;
  assign out_last       = out_last_r;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_FULL)
    else $error("slot count above table size");
`endif

endmodule
